### sv/imu_burst_frame_parser_top_macros.svh
// Assertion macros for the inertial sensor burst parser.
// Included by the top level only; no other dependencies.
`ifndef IMU_BURST_FRAME_PARSER_TOP_MACROS_SVH
`define IMU_BURST_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBFP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IBFP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ibfp_pkg.sv
// Shared types and constants for the inertial sensor burst parser.
// No dependencies; used by every module of the block.
package ibfp_pkg;

    localparam int unsigned NUM_VALUES = 9;
    localparam int unsigned NUM_PACKETS = 3;

    localparam logic [5:0] FRAME_LEN = 6'd33;
    localparam logic [5:0] POS_MAX = 6'd63;
    localparam logic [3:0] PKT_LAST = 4'd10;

    localparam logic [3:0] OFF_HEADER = 4'd0;
    localparam logic [3:0] OFF_TYPE = 4'd1;
    localparam logic [3:0] OFF_VAL_FIRST = 4'd2;
    localparam logic [3:0] OFF_VAL_LAST = 4'd7;
    localparam logic [3:0] OFF_VAL_HIGH0 = 4'd3;
    localparam logic [3:0] OFF_SUM = 4'd10;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_BASE = 8'h51;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } in_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               accel_updated;
        logic               rate_updated;
        logic               angle_updated;
    } out_t;

    // Handshake between the input register and the parser stage.
    typedef struct packed {
        logic valid;
        in_t  data;
    } stage_t;

endpackage

### sv/ibfp_in_stage.sv
// Input register of the burst parser: holds one received byte request.
// Depends on ibfp_pkg.
module ibfp_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  ibfp_pkg::in_t  byte_data,
    output ibfp_pkg::stage_t stage,
    input  logic           take
);

    logic          valid_reg;
    logic          valid_next;
    ibfp_pkg::in_t data_reg;
    ibfp_pkg::in_t data_next;

    assign byte_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        data_next = data_reg;
        if (byte_ready)
        begin
            valid_next = byte_valid;
            if (byte_valid)
            begin
                data_next = byte_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stage.valid = valid_reg;
    assign stage.data = data_reg;

endmodule

### sv/ibfp_parser.sv
// Burst parser stage: byte position, packet sums and checks, value assembly,
// held values and the result register. Depends on ibfp_pkg.
module ibfp_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  ibfp_pkg::stage_t  stage,
    output logic              take,
    output logic              result_valid,
    input  logic              result_ready,
    output ibfp_pkg::out_t    result_data
);

    logic [5:0] pos_reg, pos_next;
    logic [3:0] off_reg, off_next;
    logic [1:0] pkt_reg, pkt_next;
    logic [7:0] sum_reg, sum_next;
    logic       hdr_ok_reg, hdr_ok_next;
    logic [2:0] pkt_ok_reg, pkt_ok_next;
    logic [7:0] low_reg, low_next;
    logic [2:0] upd_reg, upd_next;
    logic       out_valid_reg, out_valid_next;

    logic signed [15:0] pend_reg [ibfp_pkg::NUM_VALUES];
    logic signed [15:0] pend_next [ibfp_pkg::NUM_VALUES];
    logic signed [15:0] held_reg [ibfp_pkg::NUM_VALUES];
    logic signed [15:0] held_next [ibfp_pkg::NUM_VALUES];

    logic [7:0] b;
    logic [3:0] val_idx;
    logic       frame_good;

    assign b = stage.data.rx_byte;
    // A byte without an end mark never touches the result register.
    assign take = stage.valid && (!stage.data.burst_end || !out_valid_reg || result_ready);
    assign val_idx = 4'(4'(pkt_reg) * 4'd3) + 4'((off_reg - ibfp_pkg::OFF_VAL_HIGH0) >> 1);

    always_comb
    begin
        pos_next = pos_reg;
        off_next = off_reg;
        pkt_next = pkt_reg;
        sum_next = sum_reg;
        hdr_ok_next = hdr_ok_reg;
        pkt_ok_next = pkt_ok_reg;
        low_next = low_reg;
        upd_next = upd_reg;
        pend_next = pend_reg;
        held_next = held_reg;
        frame_good = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;

        if (take)
        begin
            if (pos_reg >= ibfp_pkg::FRAME_LEN)
            begin
                if (pos_reg != ibfp_pkg::POS_MAX)
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
            else
            begin
                case (off_reg)
                    ibfp_pkg::OFF_HEADER:
                    begin
                        if (b != ibfp_pkg::HEADER_BYTE)
                        begin
                            hdr_ok_next = 1'b0;
                        end
                        sum_next = b;
                    end
                    ibfp_pkg::OFF_SUM:
                    begin
                        if (b != sum_reg)
                        begin
                            pkt_ok_next[pkt_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (off_reg == ibfp_pkg::OFF_TYPE
                            && b != ibfp_pkg::TYPE_BASE + 8'(pkt_reg))
                        begin
                            pkt_ok_next[pkt_reg] = 1'b0;
                        end
                        if (off_reg inside {[ibfp_pkg::OFF_VAL_FIRST:ibfp_pkg::OFF_VAL_LAST]})
                        begin
                            if (!off_reg[0])
                            begin
                                low_next = b;
                            end
                            else
                            begin
                                pend_next[val_idx] = {b, low_reg};
                            end
                        end
                        sum_next = sum_reg + b;
                    end
                endcase
                pos_next = pos_reg + 6'd1;
                if (off_reg == ibfp_pkg::PKT_LAST)
                begin
                    off_next = '0;
                    pkt_next = pkt_reg + 2'd1;
                end
                else
                begin
                    off_next = off_reg + 4'd1;
                end
            end

            if (stage.data.burst_end)
            begin
                // The end byte of a good burst is a sum byte, so the pending
                // values are complete here.
                frame_good = (pos_next == ibfp_pkg::FRAME_LEN) && hdr_ok_next;
                for (int k = 0; k < ibfp_pkg::NUM_PACKETS; k++)
                begin
                    upd_next[k] = frame_good && pkt_ok_next[k];
                    for (int i = 0; i < 3; i++)
                    begin
                        if (upd_next[k])
                        begin
                            held_next[k * 3 + i] = pend_reg[k * 3 + i];
                        end
                    end
                end
                out_valid_next = 1'b1;
                pos_next = '0;
                off_next = '0;
                pkt_next = '0;
                sum_next = '0;
                hdr_ok_next = 1'b1;
                pkt_ok_next = 3'b111;
                low_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            off_reg <= '0;
            pkt_reg <= '0;
            sum_reg <= '0;
            hdr_ok_reg <= 1'b1;
            pkt_ok_reg <= 3'b111;
            low_reg <= '0;
            upd_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ibfp_pkg::NUM_VALUES; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg <= pos_next;
            off_reg <= off_next;
            pkt_reg <= pkt_next;
            sum_reg <= sum_next;
            hdr_ok_reg <= hdr_ok_next;
            pkt_ok_reg <= pkt_ok_next;
            low_reg <= low_next;
            upd_reg <= upd_next;
            out_valid_reg <= out_valid_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // Held values only change when an end byte is taken, which needs a free
    // result slot, so they double as the result payload.
    assign result_valid = out_valid_reg;
    assign result_data.accel_x = held_reg[0];
    assign result_data.accel_y = held_reg[1];
    assign result_data.accel_z = held_reg[2];
    assign result_data.rate_x = held_reg[3];
    assign result_data.rate_y = held_reg[4];
    assign result_data.rate_z = held_reg[5];
    assign result_data.roll = held_reg[6];
    assign result_data.pitch = held_reg[7];
    assign result_data.yaw = held_reg[8];
    assign result_data.accel_updated = upd_reg[0];
    assign result_data.rate_updated = upd_reg[1];
    assign result_data.angle_updated = upd_reg[2];

endmodule

### sv/imu_burst_frame_parser_top.sv
// Inertial sensor burst parser. Takes one received byte per cycle while no
// end-marked byte waits; a byte is registered in the input register on entry and
// then parsed, so the result for a burst becomes valid at the clock edge where its
// end-marked byte leaves the input register. Bytes without an end mark flow at one
// per cycle regardless of the result side; an end-marked byte waits in the input
// register only while the previous result has not yet been taken. A burst is
// accepted only at exactly 33 bytes with 0x55 at bytes 0, 11 and 22; each good
// packet then replaces its group of three held raw Q15 values. Every end mark
// yields one result carrying all nine held values and three update flags. Depends
// on ibfp_pkg, ibfp_in_stage and ibfp_parser.
`include "imu_burst_frame_parser_top_macros.svh"

module imu_burst_frame_parser_top
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  ibfp_pkg::in_t  byte_data,
    output logic           result_valid,
    input  logic           result_ready,
    output ibfp_pkg::out_t result_data
);

    ibfp_pkg::stage_t stage;
    logic             take;

    ibfp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .stage      (stage),
        .take       (take)
    );

    ibfp_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .take         (take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // An end-marked request must stall while the result slot is occupied.
    `IBFP_ASSERT_SAME(a_end_waits, clk, rst_n, stage.valid && stage.data.burst_end && result_valid && !result_ready, !take, "end byte advanced over a pending result")
    // Every taken end byte produces a result in the next cycle.
    `IBFP_ASSERT_NEXT(a_end_yields, clk, rst_n, take && stage.data.burst_end, result_valid, "end byte produced no result")
    // Mid-burst bytes must not disturb a stalled result.
    `IBFP_ASSERT_NEXT(a_mid_quiet, clk, rst_n, take && !stage.data.burst_end && result_valid && !result_ready, result_valid && $stable(result_data), "mid-burst byte disturbed a pending result")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the inertial sensor burst parser: directed bursts,
// back-pressure and random bursts, checked against a built-in parser model.
// Depends on ibfp_pkg and imu_burst_frame_parser_top.
`timescale 1ns / 100ps

module tb_top;

    localparam int PKT_BYTES = 11;
    localparam int VALS_PER_PKT = ibfp_pkg::NUM_VALUES / ibfp_pkg::NUM_PACKETS;
    localparam int HOLD_OFF_CYCLES = 400;

    logic clk;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    ibfp_pkg::in_t byte_data = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    ibfp_pkg::out_t result_data;

    imu_burst_frame_parser_top uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_data(byte_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data(result_data)
    );

    // Parser model state.
    logic [5:0] burst_pos;
    logic [7:0] pkt_sum;
    logic hdr_good;
    logic [2:0] pkt_good;
    logic [7:0] low_latch;
    logic [15:0] burst_vals[ibfp_pkg::NUM_VALUES];
    logic [15:0] held_vals[ibfp_pkg::NUM_VALUES];

    ibfp_pkg::out_t reports_due[$];
    logic [7:0] frame_q[$];

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int hold_left = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int reports_checked = 0;
    int groups_replaced = 0;
    int reports_unchanged = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_burst();
        burst_pos = '0;
        pkt_sum = '0;
        hdr_good = 1'b1;
        pkt_good = 3'b111;
        low_latch = '0;
    endfunction

    // Advances the model by one accepted byte and queues the report an end mark produces.
    function automatic void parse_byte(ibfp_pkg::in_t item);
        int pk;
        int off;
        int k;
        int i;
        logic [2:0] upd;
        ibfp_pkg::out_t rpt;
        pk = int'(burst_pos) / PKT_BYTES;
        off = int'(burst_pos) % PKT_BYTES;
        if (burst_pos >= ibfp_pkg::FRAME_LEN)
        begin
            if (burst_pos != ibfp_pkg::POS_MAX)
                burst_pos++;
        end
        else
        begin
            if (off == ibfp_pkg::OFF_HEADER)
            begin
                if (item.rx_byte != ibfp_pkg::HEADER_BYTE)
                    hdr_good = 1'b0;
                pkt_sum = item.rx_byte;
            end
            else if (off == ibfp_pkg::OFF_SUM)
            begin
                if (item.rx_byte != pkt_sum)
                    pkt_good[pk] = 1'b0;
            end
            else
            begin
                if (off == ibfp_pkg::OFF_TYPE
                    && item.rx_byte != ibfp_pkg::TYPE_BASE + 8'(pk))
                    pkt_good[pk] = 1'b0;
                if (off >= ibfp_pkg::OFF_VAL_FIRST && off <= ibfp_pkg::OFF_VAL_LAST)
                begin
                    // Low byte arrives first; the high byte completes the value.
                    if (off % 2 == 0)
                        low_latch = item.rx_byte;
                    else
                        burst_vals[pk * VALS_PER_PKT + (off - ibfp_pkg::OFF_VAL_HIGH0) / 2] =
                            {item.rx_byte, low_latch};
                end
                pkt_sum = pkt_sum + item.rx_byte;
            end
            burst_pos++;
        end
        if (!item.burst_end)
            return;
        upd = '0;
        if (burst_pos == ibfp_pkg::FRAME_LEN && hdr_good)
        begin
            for (k = 0; k < ibfp_pkg::NUM_PACKETS; k++)
            begin
                if (pkt_good[k])
                begin
                    for (i = 0; i < VALS_PER_PKT; i++)
                        held_vals[k * VALS_PER_PKT + i] = burst_vals[k * VALS_PER_PKT + i];
                    upd[k] = 1'b1;
                    groups_replaced++;
                end
            end
        end
        if (upd == '0)
            reports_unchanged++;
        rpt.accel_x = held_vals[0];
        rpt.accel_y = held_vals[1];
        rpt.accel_z = held_vals[2];
        rpt.rate_x = held_vals[3];
        rpt.rate_y = held_vals[4];
        rpt.rate_z = held_vals[5];
        rpt.roll = held_vals[6];
        rpt.pitch = held_vals[7];
        rpt.yaw = held_vals[8];
        rpt.accel_updated = upd[0];
        rpt.rate_updated = upd[1];
        rpt.angle_updated = upd[2];
        reports_due.push_back(rpt);
        clear_burst();
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want),
                $signed(got));
        end
    endfunction

    initial
    begin
        clear_burst();
        for (int i = 0; i < ibfp_pkg::NUM_VALUES; i++)
        begin
            burst_vals[i] = '0;
            held_vals[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
            parse_byte(byte_data);
    end

    always @(posedge clk)
    begin : result_check
        ibfp_pkg::out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (reports_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected report, expected none, got %h", $time, result_data);
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("accel_x", want.accel_x, result_data.accel_x);
                check_field("accel_y", want.accel_y, result_data.accel_y);
                check_field("accel_z", want.accel_z, result_data.accel_z);
                check_field("rate_x", want.rate_x, result_data.rate_x);
                check_field("rate_y", want.rate_y, result_data.rate_y);
                check_field("rate_z", want.rate_z, result_data.rate_z);
                check_field("roll", want.roll, result_data.roll);
                check_field("pitch", want.pitch, result_data.pitch);
                check_field("yaw", want.yaw, result_data.yaw);
                check_field("accel_updated", want.accel_updated, result_data.accel_updated);
                check_field("rate_updated", want.rate_updated, result_data.rate_updated);
                check_field("angle_updated", want.angle_updated, result_data.angle_updated);
                reports_checked++;
            end
        end
    end

    // Receiver: a hold-off stretch overrides the random stalls.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Called right after a rising edge; returns at the edge where the request was taken.
    task automatic send_byte(ibfp_pkg::in_t item);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        ibfp_pkg::in_t item;
        int i;
        for (i = 0; i < frame_q.size(); i++)
        begin
            item.rx_byte = frame_q[i];
            item.burst_end = (i == frame_q.size() - 1);
            send_byte(item);
        end
    endtask

    // The extra edge lets the model log the last accepted byte before the queue is read.
    task automatic wait_drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Appends one well-formed packet with the given values and a correct sum.
    function automatic void add_packet(int k, logic [15:0] v0, logic [15:0] v1,
                                       logic [15:0] v2, logic [7:0] pad);
        logic [7:0] sum;
        int start;
        start = frame_q.size();
        frame_q.push_back(ibfp_pkg::HEADER_BYTE);
        frame_q.push_back(ibfp_pkg::TYPE_BASE + 8'(k));
        frame_q.push_back(v0[7:0]);
        frame_q.push_back(v0[15:8]);
        frame_q.push_back(v1[7:0]);
        frame_q.push_back(v1[15:8]);
        frame_q.push_back(v2[7:0]);
        frame_q.push_back(v2[15:8]);
        frame_q.push_back(pad);
        frame_q.push_back(~pad);
        sum = '0;
        for (int i = start; i < frame_q.size(); i++)
            sum = sum + frame_q[i];
        frame_q.push_back(sum);
    endfunction

    function automatic void random_frame();
        frame_q = {};
        for (int k = 0; k < ibfp_pkg::NUM_PACKETS; k++)
            add_packet(k, pick_value(), pick_value(), pick_value(), 8'($urandom));
    endfunction

    function automatic void flip_byte(int idx);
        frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(255, 1));
    endfunction

    task automatic test_directed();
        random_frame();
        frame_q = {};
        add_packet(0, 16'h7FFF, 16'h8000, 16'h0000, 8'hFF);
        add_packet(1, 16'hFFFF, 16'h0001, 16'h8000, 8'h00);
        add_packet(2, 16'h7FFF, 16'h7FFF, 16'h8000, 8'hA5);
        send_frame();
        frame_q = {};
        add_packet(0, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
        add_packet(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_packet(2, 16'h0000, 16'hFFFF, 16'h0000, 8'h00);
        send_frame();
        // Bursts too short to count, down to a lone end-marked byte.
        frame_q = {8'h55};
        send_frame();
        frame_q = {8'h00};
        send_frame();
        frame_q = {8'hFF};
        send_frame();
        random_frame();
        void'(frame_q.pop_back());
        send_frame();
        // Bad header in the last packet rejects the whole burst.
        random_frame();
        frame_q[2 * PKT_BYTES] = 8'h54;
        send_frame();
        // Wrong type byte in the first packet, wrong sum in the second.
        random_frame();
        frame_q[ibfp_pkg::OFF_TYPE] = ibfp_pkg::TYPE_BASE + 8'd1;
        frame_q[PKT_BYTES + ibfp_pkg::OFF_SUM] = frame_q[PKT_BYTES + ibfp_pkg::OFF_SUM] + 8'd1;
        send_frame();
        random_frame();
        frame_q[2 * PKT_BYTES + ibfp_pkg::OFF_TYPE] = ibfp_pkg::TYPE_BASE;
        send_frame();
        // One byte too many, then far past the saturating count.
        random_frame();
        frame_q.push_back(8'h55);
        send_frame();
        random_frame();
        repeat (40)
            frame_q.push_back(8'($urandom));
        send_frame();
        // Right length and headers, random content.
        frame_q = {};
        for (int i = 0; i < ibfp_pkg::FRAME_LEN; i++)
            frame_q.push_back((i % PKT_BYTES == 0) ? ibfp_pkg::HEADER_BYTE : 8'($urandom));
        send_frame();
        wait_drain();
    endtask

    // Receiver holds off while end marks keep coming, so the input side must stall.
    task automatic test_backpressure();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        repeat (6)
        begin
            frame_q = {8'($urandom)};
            send_frame();
        end
        repeat (2)
        begin
            random_frame();
            send_frame();
        end
        wait_drain();
    endtask

    task automatic random_burst();
        int kind;
        int k;
        kind = $urandom_range(99);
        random_frame();
        if (kind < 70)
        begin
            for (k = 0; k < ibfp_pkg::NUM_PACKETS; k++)
            begin
                if ($urandom_range(99) < 15)
                    flip_byte(k * PKT_BYTES + ibfp_pkg::OFF_TYPE);
                if ($urandom_range(99) < 15)
                    flip_byte(k * PKT_BYTES + ibfp_pkg::OFF_SUM);
            end
        end
        else if (kind < 80)
        begin
            frame_q = frame_q[0:$urandom_range(ibfp_pkg::FRAME_LEN - 2, 0)];
        end
        else if (kind < 88)
        begin
            repeat ($urandom_range(36, 1))
                frame_q.push_back(8'($urandom));
        end
        else if (kind < 94)
        begin
            flip_byte($urandom_range(ibfp_pkg::NUM_PACKETS - 1) * PKT_BYTES);
        end
        else
        begin
            frame_q = {};
            repeat ($urandom_range(40, 1))
                frame_q.push_back(8'($urandom));
        end
        send_frame();
    endtask

    task automatic test_random(int src_pct, int dst_pct, int n_bytes);
        int start;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            random_burst();
        wait_drain();
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(32, 72, 160);
        test_random(72, 32, 160);
        test_random(0, 0, 160);
        repeat (10)
            @(posedge clk);
        $display("Sent %0d bytes and checked %0d reports: %0d groups replaced, %0d reports",
            bytes_sent, reports_checked, groups_replaced, reports_unchanged);
        $display("with nothing replaced, across idle mixes and a %0d-cycle receiver hold-off.",
            HOLD_OFF_CYCLES);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/ibfp_pkg.sv
sv/ibfp_in_stage.sv
sv/ibfp_parser.sv
sv/imu_burst_frame_parser_top.sv
tb/tb_top.sv
